/* hdl/andt_pkg.sv */
package andt_pkg;

  localparam int unsigned Entries  = 32;
  localparam int unsigned NameMax  = 31;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CntW     = 6;
  localparam int unsigned NposW    = 5;
  localparam int unsigned NameMemD = Entries * NameMax;
  localparam int unsigned NameAdrW = 10;

  localparam logic [7:0] AdTypeShortName = 8'h08;
  localparam logic [7:0] AdTypeFullName  = 8'h09;

  typedef enum logic [1:0] {
    FuncData  = 2'd0,
    FuncClear = 2'd1,
    FuncRead  = 2'd2,
    FuncNop   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StNone  = 2'd0,
    StAdded = 2'd1,
    StSeen  = 2'd2,
    StFull  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PhLen  = 2'd0,
    PhType = 2'd1,
    PhData = 2'd2,
    PhSkip = 2'd3
  } phase_e;

  // request sequencer states
  typedef enum logic [1:0] {
    SIdle = 2'd0,
    SRead = 2'd1,
    SOut  = 2'd2
  } seq_e;

  // input request: highest bit first
  typedef struct packed {
    logic [4:0]  name_pos;
    logic [4:0]  entry_index;
    logic        first_byte;
    logic [7:0]  adv_byte;
    logic [7:0]  addr_kind;
    logic [47:0] dev_addr;
    logic [1:0]  func;
  } req_t;

  // result: highest bit first
  typedef struct packed {
    logic [7:0]  entry_name_byte;
    logic [4:0]  entry_name_len;
    logic [7:0]  entry_addr_kind;
    logic [47:0] entry_addr;
    logic        entry_valid;
    logic [5:0]  entry_count;
    logic [1:0]  status;
  } rsp_t;

  // control from sequencer down the cell row
  typedef struct packed {
    logic        search;
    logic [47:0] addr;
    logic        write;
    logic [IdxW-1:0] wr_idx;
    logic [47:0] wr_addr;
    logic [7:0]  wr_kind;
    logic [4:0]  wr_len;
    logic [IdxW-1:0] rd_idx;
  } cell_ctl_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic        hit;
    logic [47:0] addr;
    logic [7:0]  kind;
    logic [4:0]  len;
  } chain_t;

endpackage

/* hdl/andt_cell.sv */
module andt_cell (
  input  logic                   clk_i,
  input  logic [andt_pkg::IdxW-1:0] my_idx_i,
  input  andt_pkg::cell_ctl_t    ctl_i,
  input  logic                   live_i,
  input  andt_pkg::chain_t       chain_i,
  output andt_pkg::chain_t       chain_o
);
  import andt_pkg::*;

  logic [47:0] addr_q;
  logic [7:0]  kind_q;
  logic [4:0]  len_q;
  logic        sel;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.write && ctl_i.wr_idx == my_idx_i) begin
      addr_q <= ctl_i.wr_addr;
      kind_q <= ctl_i.wr_kind;
      len_q  <= ctl_i.wr_len;
    end
  end

  // compare hit ors into the chain, read entry is picked off in passing
  assign sel = (ctl_i.rd_idx == my_idx_i);
  always_comb begin
    chain_o.hit  = chain_i.hit | (live_i && ctl_i.search && addr_q == ctl_i.addr);
    chain_o.addr = sel ? addr_q : chain_i.addr;
    chain_o.kind = sel ? kind_q : chain_i.kind;
    chain_o.len  = sel ? len_q  : chain_i.len;
  end
endmodule

/* hdl/adv_name_dedup_table.sv */
// Advertising-name duplicate filter for 32 devices. Each accepted request
// (func: data byte, clear, read, nop) gives exactly one result. Requests are
// taken one at a time: the row of entry cells is searched and the addressed
// entry latched in the accepting cycle, the byte is parsed and the name memory
// read in the next (SRead), and the result is presented in SOut and held until
// taken. tready is low from the accept until the result is taken, so output
// stalls add directly to the request time. Entry cells sit in a chain that ors
// the address hits and carries the addressed entry along.
module adv_name_dedup_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // func, dev_addr, addr_kind, adv_byte, first_byte, entry_index, name_pos
  input  logic [79:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status, entry_count, entry_valid, entry_addr, entry_addr_kind,
  // entry_name_len, entry_name_byte
  output logic [79:0] m_axis_tdata_o
);
  import andt_pkg::*;

  seq_e        st_q, st_d;
  req_t        req_q;
  logic        last_q;
  rsp_t        rsp_q;
  logic [CntW-1:0] count_q;
  phase_e      ph_q;
  logic [7:0]  left_q;
  logic        inname_q, stopped_q, open_q;
  logic [4:0]  nwr_q;
  logic [47:0] caddr_q;
  logic [7:0]  ckind_q;
  logic [7:0]  nmem [NameMemD];
  logic [7:0]  nrd_q;
  chain_t      ent_q;
  logic        hit_q;

  cell_ctl_t   ctl;
  chain_t      chain [Entries+1];

  assign s_axis_tready_o = (st_q == SIdle);
  assign m_axis_tvalid_o = (st_q == SOut);

  // cell row
  assign chain[0] = '0;
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    andt_cell u_cell (
      .clk_i   (clk_i),
      .my_idx_i(IdxW'(g)),
      .ctl_i   (ctl),
      .live_i  (IdxW'(g) < count_q[IdxW-1:0] || count_q[CntW-1]),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  // parse logic on the held request (stage SRead)
  logic        fd;
  status_e     stat;
  phase_e      ph_n;
  logic [7:0]  left_n;
  logic        inname_n, stopped_n, open_n;
  logic [4:0]  nwr_n;
  logic [CntW-1:0] count_n;
  logic        commit, nwrite;
  logic [NameAdrW-1:0] nwaddr;
  logic [47:0] caddr_n;
  logic [7:0]  ckind_n;
  logic        full;

  assign full = (count_q >= CntW'(Entries));

  always_comb begin
    stat = StNone; ph_n = ph_q; left_n = left_q; inname_n = inname_q;
    stopped_n = stopped_q; open_n = open_q; nwr_n = nwr_q; count_n = count_q;
    commit = 1'b0; nwrite = 1'b0; caddr_n = caddr_q; ckind_n = ckind_q;
    fd = 1'b0;
    nwaddr = NameAdrW'(count_q[IdxW-1:0] * NameMax) + NameAdrW'(nwr_q);
    unique case (func_e'(req_q.func))
      FuncData: begin
        if (req_q.first_byte) begin
          open_n = 1'b1; caddr_n = req_q.dev_addr; ckind_n = req_q.addr_kind;
          left_n = '0; inname_n = 1'b0; nwr_n = '0; stopped_n = 1'b0;
          nwaddr = NameAdrW'(count_q[IdxW-1:0] * NameMax);
          if (hit_q) begin stat = StSeen; ph_n = PhSkip; end
          else if (full) begin stat = StFull; ph_n = PhSkip; end
          else ph_n = PhLen;
        end
        fd = open_n && stat == StNone;
        if (fd) begin
          unique case (ph_n)
            PhLen: begin
              if (req_q.adv_byte == 8'd0) ph_n = PhSkip;
              else begin left_n = req_q.adv_byte; ph_n = PhType; end
            end
            PhType: begin
              left_n   = left_n - 8'd1;
              inname_n = (req_q.adv_byte == AdTypeShortName) ||
                         (req_q.adv_byte == AdTypeFullName);
              nwr_n = '0; stopped_n = 1'b0;
              nwaddr = NameAdrW'(count_q[IdxW-1:0] * NameMax);
              if (left_n == 8'd0) begin
                if (inname_n) commit = 1'b1; else ph_n = PhLen;
              end else ph_n = PhData;
            end
            PhData: begin
              if (inname_n && !stopped_n && nwr_n < 5'(NameMax)) begin
                if (req_q.adv_byte == 8'd0) stopped_n = 1'b1;
                else if (!full) begin nwrite = 1'b1; nwr_n = nwr_n + 5'd1; end
              end
              left_n = left_n - 8'd1;
              if (left_n == 8'd0) begin
                if (inname_n) commit = 1'b1; else ph_n = PhLen;
              end
            end
            default: ;
          endcase
          if (commit) begin
            stat = StAdded; ph_n = PhSkip;
            if (!full) count_n = count_q + CntW'(1);
          end
        end
        if (last_q) begin
          open_n = 1'b0; ph_n = PhLen; left_n = '0; inname_n = 1'b0;
        end
      end
      FuncClear: begin
        count_n = '0; open_n = 1'b0; ph_n = PhLen; left_n = '0;
        inname_n = 1'b0; nwr_n = '0; stopped_n = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.search  = (st_q == SIdle);
    ctl.addr    = s_axis_tdata_i[49:2];
    ctl.rd_idx  = s_axis_tdata_i[71:67];
    ctl.write   = (st_q == SRead) && commit && !full;
    ctl.wr_idx  = count_q[IdxW-1:0];
    ctl.wr_addr = caddr_n;
    ctl.wr_kind = ckind_n;
    ctl.wr_len  = nwr_n;
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (s_axis_tvalid_i) st_d = SRead;
      SRead: st_d = SOut;
      SOut:  if (m_axis_tready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; count_q <= '0; ph_q <= PhLen; left_q <= '0;
      inname_q <= 1'b0; stopped_q <= 1'b0; open_q <= 1'b0; nwr_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == SRead) begin
        count_q <= count_n; ph_q <= ph_n; left_q <= left_n;
        inname_q <= inname_n; stopped_q <= stopped_n; open_q <= open_n;
        nwr_q <= nwr_n;
      end
    end
  end

  // payload and name memory
  logic [NameAdrW-1:0] nraddr;
  assign nraddr = NameAdrW'(req_q.entry_index * NameMax) + NameAdrW'(req_q.name_pos);

  logic rd_ok;
  assign rd_ok = (func_e'(req_q.func) == FuncRead) &&
                 (CntW'(req_q.entry_index) < count_q);

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && s_axis_tvalid_i) begin
      req_q  <= req_t'(s_axis_tdata_i[76:0]);
      last_q <= s_axis_tlast_i;
      ent_q  <= chain[Entries];
      hit_q  <= chain[Entries].hit;
    end
    if (st_q == SRead) begin
      caddr_q <= caddr_n;
      ckind_q <= ckind_n;
      if (nwrite) nmem[nwaddr] <= req_q.adv_byte;
      nrd_q <= nmem[nraddr];
      rsp_q.status          <= stat;
      rsp_q.entry_count     <= count_n;
      rsp_q.entry_valid     <= rd_ok;
      rsp_q.entry_addr      <= rd_ok ? ent_q.addr : '0;
      rsp_q.entry_addr_kind <= rd_ok ? ent_q.kind : '0;
      rsp_q.entry_name_len  <= rd_ok ? ent_q.len : '0;
      rsp_q.entry_name_byte <= '0;
    end
  end

  logic nb_ok;
  always_ff @(posedge clk_i) begin
    if (st_q == SRead) nb_ok <= rd_ok && req_q.name_pos < ent_q.len;
  end

  // name byte joins the registered result at presentation
  always_comb begin
    rsp_t r;
    r = rsp_q;
    r.entry_name_byte = nb_ok ? nrd_q : 8'd0;
    m_axis_tdata_o = {2'b00, r};
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Entries)) else $error("count beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SRead |=> st_q == SOut) else $error("sequencer skipped result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SOut && !m_axis_tready_i |=> $stable(rsp_q)) else $error("result moved");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.write |-> !full) else $error("write into full table");
endmodule

/* dv/tb_adv_name_dedup_table.sv */
module tb_adv_name_dedup_table;
  timeunit 1ns;
  timeprecision 1ps;

  import andt_pkg::*;

  typedef struct {
    req_t req;
    logic last;
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // func, dev_addr, addr_kind, adv_byte, first_byte, entry_index, name_pos
  logic [79:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // status, entry_count, entry_valid, entry_addr, entry_addr_kind,
  // entry_name_len, entry_name_byte
  logic [79:0] m_axis_tdata_o;

  adv_name_dedup_table u_top (.*);

  // clock and reset
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // table mirror
  logic [47:0] tbl_addr [Entries];
  logic [7:0]  tbl_kind [Entries];
  int unsigned tbl_len  [Entries];
  logic [7:0]  tbl_name [Entries][NameMax];
  int unsigned tbl_count;
  phase_e      prs_phase;
  int unsigned prs_left;
  logic        prs_in_name;
  int unsigned prs_written;
  logic        prs_stopped;
  logic        rpt_open;
  logic [47:0] rpt_addr;
  logic [7:0]  rpt_kind;

  initial begin
    tbl_count   = 0;
    prs_phase   = PhLen;
    prs_left    = 0;
    prs_in_name = 1'b0;
    prs_written = 0;
    prs_stopped = 1'b0;
    rpt_open    = 1'b0;
    rpt_addr    = '0;
    rpt_kind    = '0;
  end

  // end of a structure: commit a name or look for the next length
  function automatic status_e close_struct();
    if (prs_in_name) begin
      if (tbl_count < Entries) begin
        tbl_addr[tbl_count] = rpt_addr;
        tbl_kind[tbl_count] = rpt_kind;
        tbl_len[tbl_count]  = prs_written;
        tbl_count++;
      end
      prs_phase = PhSkip;
      return StAdded;
    end
    prs_phase = PhLen;
    return StNone;
  endfunction

  function automatic status_e parse_byte(logic [7:0] b);
    status_e st;
    st = StNone;
    case (prs_phase)
      PhLen: begin
        if (b == 8'd0) prs_phase = PhSkip;
        else begin
          prs_left  = b;
          prs_phase = PhType;
        end
      end
      PhType: begin
        prs_left    = (prs_left - 1) & 8'hff;
        prs_in_name = (b == AdTypeShortName) || (b == AdTypeFullName);
        prs_written = 0;
        prs_stopped = 1'b0;
        if (prs_left == 0) st = close_struct();
        else prs_phase = PhData;
      end
      PhData: begin
        if (prs_in_name && !prs_stopped && prs_written < NameMax) begin
          if (b == 8'd0) prs_stopped = 1'b1;
          else if (tbl_count < Entries) begin
            tbl_name[tbl_count][prs_written] = b;
            prs_written++;
          end
        end
        prs_left = (prs_left - 1) & 8'hff;
        if (prs_left == 0) st = close_struct();
      end
      default: ;
    endcase
    return st;
  endfunction

  // expected result of one request, updates the mirror
  function automatic rsp_t predict_result(req_t r, logic last);
    rsp_t    o;
    status_e st;
    logic    known;
    o  = '0;
    st = StNone;
    case (func_e'(r.func))
      FuncData: begin
        if (r.first_byte) begin
          known = 1'b0;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_addr[i] == r.dev_addr) known = 1'b1;
          rpt_open    = 1'b1;
          rpt_addr    = r.dev_addr;
          rpt_kind    = r.addr_kind;
          prs_left    = 0;
          prs_in_name = 1'b0;
          prs_written = 0;
          prs_stopped = 1'b0;
          if (known) begin
            st = StSeen;
            prs_phase = PhSkip;
          end else if (tbl_count >= Entries) begin
            st = StFull;
            prs_phase = PhSkip;
          end else prs_phase = PhLen;
        end
        if (rpt_open && st == StNone) st = parse_byte(r.adv_byte);
        if (last) begin
          rpt_open    = 1'b0;
          prs_phase   = PhLen;
          prs_left    = 0;
          prs_in_name = 1'b0;
        end
      end
      FuncClear: begin
        tbl_count   = 0;
        rpt_open    = 1'b0;
        prs_phase   = PhLen;
        prs_left    = 0;
        prs_in_name = 1'b0;
        prs_written = 0;
        prs_stopped = 1'b0;
      end
      FuncRead: begin
        if (r.entry_index < tbl_count) begin
          o.entry_valid     = 1'b1;
          o.entry_addr      = tbl_addr[r.entry_index];
          o.entry_addr_kind = tbl_kind[r.entry_index];
          o.entry_name_len  = 5'(tbl_len[r.entry_index]);
          if (r.name_pos < tbl_len[r.entry_index])
            o.entry_name_byte = tbl_name[r.entry_index][r.name_pos];
        end
      end
      default: ;
    endcase
    o.status      = st;
    o.entry_count = 6'(tbl_count);
    return o;
  endfunction

  // request building
  beat_t       pending_reqs [$];
  rsp_t        expected_results [$];
  logic [47:0] addr_pool [8];

  function automatic logic [47:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic req_t base_req(func_e f);
    req_t r;
    r             = '0;
    r.func        = f;
    r.dev_addr    = rand_addr();
    r.addr_kind   = 8'($urandom);
    r.adv_byte    = 8'($urandom);
    r.entry_index = 5'($urandom);
    r.name_pos    = 5'($urandom_range(0, NameMax - 1));
    return r;
  endfunction

  function automatic void push_req(req_t r, logic last);
    beat_t b;
    b.req  = r;
    b.last = last;
    pending_reqs.push_back(b);
  endfunction

  function automatic void push_report(logic [47:0] a, logic [7:0] k, logic [7:0] bytes [$]);
    req_t r;
    for (int i = 0; i < bytes.size(); i++) begin
      r            = base_req(FuncData);
      r.dev_addr   = a;
      r.addr_kind  = k;
      r.adv_byte   = bytes[i];
      r.first_byte = (i == 0);
      push_req(r, i == bytes.size() - 1);
      // reads slipped in between report bytes
      if ($urandom_range(0, 19) == 0) push_req(base_req(FuncRead), 1'($urandom));
    end
  endfunction

  // one structure: length, type, payload
  function automatic void add_struct(ref logic [7:0] bytes [$], input logic [7:0] typ,
                                     input int unsigned plen, input logic zero_ok);
    bytes.push_back(8'(plen + 1));
    bytes.push_back(typ);
    for (int i = 0; i < plen; i++)
      bytes.push_back((zero_ok && $urandom_range(0, 15) == 0) ? 8'd0
                                                             : 8'($urandom_range(1, 255)));
  endfunction

  function automatic void add_random_report();
    logic [7:0]  bytes [$];
    logic [47:0] a;
    int unsigned n;
    logic [7:0]  typ;
    a = ($urandom_range(0, 3) == 0) ? addr_pool[$urandom_range(0, 7)] : rand_addr();
    n = $urandom_range(1, 3);
    for (int s = 0; s < n; s++) begin
      case ($urandom_range(0, 5))
        0, 1: typ = AdTypeFullName;
        2:    typ = AdTypeShortName;
        default: typ = 8'($urandom);
      endcase
      add_struct(bytes, typ, ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45)
                                                        : $urandom_range(0, 10), 1'b1);
    end
    case ($urandom_range(0, 9))
      0: bytes.insert($urandom_range(0, bytes.size() - 1), 8'd0);
      1: if (bytes.size() > 2) void'(bytes.pop_back());
      2: bytes.push_back(8'($urandom));
      default: ;
    endcase
    push_report(a, 8'($urandom), bytes);
  endfunction

  // stimulus
  initial begin
    logic [7:0] bytes [$];
    req_t       r;
    for (int i = 0; i < 8; i++) addr_pool[i] = rand_addr();
    addr_pool[0] = '0;
    addr_pool[1] = '1;

    // byte outside any report
    push_req(base_req(FuncData), 1'b0);
    // three-byte full name with extreme fields
    bytes = {};
    add_struct(bytes, AdTypeFullName, 3, 1'b0);
    push_report(addr_pool[1], 8'hff, bytes);
    // duplicate of that address
    push_report(addr_pool[1], 8'h00, bytes);
    // empty name, all-zero address
    bytes = {8'd1, AdTypeShortName};
    push_report(addr_pool[0], 8'h00, bytes);
    // name cut at a zero byte after a non-name structure
    bytes = {8'd2, 8'h01, 8'h06, 8'd5, AdTypeFullName, 8'h41, 8'h00, 8'h42, 8'h43};
    push_report(addr_pool[2], 8'h01, bytes);
    // long name clipped to the maximum
    bytes = {};
    add_struct(bytes, AdTypeFullName, 40, 1'b0);
    push_report(addr_pool[3], 8'h5a, bytes);
    // zero length byte, then structure past the report end
    push_report(addr_pool[4], 8'h02, {8'd0, 8'd2, AdTypeFullName, 8'h41});
    push_report(addr_pool[4], 8'h02, {8'd4, AdTypeFullName, 8'h41});
    // new first byte mid-report: open report left without a last byte
    r = base_req(FuncData);
    r.dev_addr   = addr_pool[5];
    r.addr_kind  = 8'h03;
    r.adv_byte   = 8'd4;
    r.first_byte = 1'b1;
    push_req(r, 1'b0);
    r.adv_byte   = AdTypeShortName;
    r.first_byte = 1'b0;
    push_req(r, 1'b0);
    push_report(addr_pool[5], 8'h03, {8'd2, AdTypeShortName, 8'h7e});
    push_req(base_req(FuncNop), 1'b1);
    r = base_req(FuncRead);
    r.entry_index = 0;
    r.name_pos = 0;
    push_req(r, 1'b0);
    // clear while a report is still open
    r = base_req(FuncData);
    r.dev_addr   = addr_pool[6];
    r.addr_kind  = 8'h04;
    r.adv_byte   = 8'd4;
    r.first_byte = 1'b1;
    push_req(r, 1'b0);
    r.adv_byte   = AdTypeFullName;
    r.first_byte = 1'b0;
    push_req(r, 1'b0);
    r.adv_byte   = 8'h31;
    push_req(r, 1'b0);
    push_req(base_req(FuncClear), 1'b0);
    r.adv_byte   = 8'h32;
    push_req(r, 1'b1);

    // random traffic
    while (pending_reqs.size() < 1320) begin
      case ($urandom_range(0, 99))
        0: push_req(base_req(FuncClear), 1'($urandom));
        1: push_req(base_req(FuncNop), 1'($urandom));
        2, 3: push_req(base_req(FuncData), 1'($urandom));
        4, 5, 6, 7, 8, 9, 10, 11: push_req(base_req(FuncRead), 1'($urandom));
        default: add_random_report();
      endcase
    end
  end

  // gap lengths: mostly none or short, a few long, some stretches with none
  logic no_idle;
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  beat_t       cur_beat;
  int unsigned drv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tlast_i  <= 1'b0;
      drv_gap         <= 0;
      no_idle         <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_results.push_back(predict_result(cur_beat.req, cur_beat.last));
      if ($urandom_range(0, 99) == 0) no_idle <= ~no_idle;
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (drv_gap > 0) begin
          drv_gap         <= drv_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_beat = pending_reqs.pop_front();
          s_axis_tdata_i  <= 80'(cur_beat.req);
          s_axis_tlast_i  <= cur_beat.last;
          s_axis_tvalid_i <= 1'b1;
          drv_gap         <= pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  int unsigned mon_gap;
  int unsigned errors;
  rsp_t        got;
  rsp_t        exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      mon_gap         <= 0;
      errors          <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = rsp_t'(m_axis_tdata_o[$bits(rsp_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status ||
              got.entry_count !== exp_r.entry_count ||
              got.entry_valid !== exp_r.entry_valid ||
              got.entry_addr !== exp_r.entry_addr ||
              got.entry_addr_kind !== exp_r.entry_addr_kind ||
              got.entry_name_len !== exp_r.entry_name_len ||
              got.entry_name_byte !== exp_r.entry_name_byte) begin
            $display("%0t: mismatch expected st=%0d cnt=%0d v=%0b a=%h k=%h len=%0d b=%h",
                     $time, exp_r.status, exp_r.entry_count, exp_r.entry_valid,
                     exp_r.entry_addr, exp_r.entry_addr_kind, exp_r.entry_name_len,
                     exp_r.entry_name_byte);
            $display("%0t: mismatch actual   st=%0d cnt=%0d v=%0b a=%h k=%h len=%0d b=%h",
                     $time, got.status, got.entry_count, got.entry_valid,
                     got.entry_addr, got.entry_addr_kind, got.entry_name_len,
                     got.entry_name_byte);
            errors <= errors + 1;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap         <= mon_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) mon_gap <= pick_gap();
      end
    end
  end

  // watchdog on cycles with no handshake
  int unsigned stall_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 2000) begin
      $display("adv_name_dedup_table verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    wait (pending_reqs.size() == 0 && !s_axis_tvalid_i && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("adv_name_dedup_table verification clean");
    end else begin
      $display("adv_name_dedup_table verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/andt_pkg.sv
hdl/andt_cell.sv
hdl/adv_name_dedup_table.sv
dv/tb_adv_name_dedup_table.sv
